>>> rtl/core/keyed_pending_packet_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Keyed pending packet queue: assertion macros
// Concurrent assertion helpers clocked on clk and held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef KEYED_PENDING_PACKET_QUEUE_CORE_DEFINES_SVH
`define KEYED_PENDING_PACKET_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KPPQ_ASSERT_HOLDS(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kppq assertion failed");
// next-cycle implication
`define KPPQ_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kppq assertion failed");
`else
`define KPPQ_ASSERT_HOLDS(lbl, ante, cons)
`define KPPQ_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/core/kppq_pkg.sv
// ----------------------------------------------------------------------------
// kppq_pkg
// Shared sizes, descriptor and command types, codes and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package kppq_pkg;

	localparam int DEPTH             = 16;
	localparam int MAX_MESSAGE_BYTES = 1023;

	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int OCC_W  = 5;
	localparam int ADDR_W = 8;
	localparam int REF_W  = 16;
	localparam int LEN_W  = 10;
	localparam int HOP_W  = 8;

	// command queue between front and back; depth is a power of two
	localparam int FIFO_DEPTH = 2;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);

	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_DELETE = 2'd2,
		OP_POP    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef struct packed {
		logic [ADDR_W-1:0] src;
		logic [ADDR_W-1:0] dst;
		logic [REF_W-1:0]  handle;
		logic [LEN_W-1:0]  len;
		logic [HOP_W-1:0]  hops;
	} entry_t;

	typedef struct packed {
		opcode_t op;
		entry_t  entry;
	} cmd_t;

	typedef struct packed {
		status_t           status;
		logic              entry_valid;
		entry_t            entry;
		logic [OCC_W-1:0]  occupancy;
	} res_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_EXEC,
		BS_SCAN,
		BS_POP_RD,
		BS_DEL_WR
	} back_state_t;

	// slot index arithmetic modulo DEPTH
	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W+1)'(DEPTH)) begin
			s = s - (IDX_W+1)'(DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// clamp stored length to the packet memory limit
	function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
		if (32'(len) > 32'(MAX_MESSAGE_BYTES)) begin
			return LEN_W'(MAX_MESSAGE_BYTES);
		end
		return len;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/kppq_front.sv
// ----------------------------------------------------------------------------
// kppq_front
// Accept input transactions, decode the opcode and register a command.
// ----------------------------------------------------------------------------
`default_nettype none

module kppq_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   opcode,
	input  wire logic [kppq_pkg::ADDR_W-1:0]  source_address,
	input  wire logic [kppq_pkg::ADDR_W-1:0]  destination_address,
	input  wire logic [kppq_pkg::REF_W-1:0]   message_reference,
	input  wire logic [kppq_pkg::LEN_W-1:0]   message_length,
	input  wire logic [kppq_pkg::HOP_W-1:0]   hop_limit,
	output logic                              cmd_valid,
	input  wire logic                         cmd_ready,
	output kppq_pkg::cmd_t                    cmd
);

	logic           valid_s1;
	kppq_pkg::cmd_t cmd_s1;
	kppq_pkg::cmd_t cmd_dec;
	logic           take;

	always_comb begin
		cmd_dec.op           = kppq_pkg::opcode_t'(opcode);
		cmd_dec.entry.src    = source_address;
		cmd_dec.entry.dst    = destination_address;
		cmd_dec.entry.handle = message_reference;
		cmd_dec.entry.len    = kppq_pkg::sat_len(message_length);
		cmd_dec.entry.hops   = hop_limit;
	end

	assign in_ready = !valid_s1 || cmd_ready;
	assign take     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (cmd_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= cmd_dec;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

>>> rtl/core/kppq_cmd_queue.sv
// ----------------------------------------------------------------------------
// kppq_cmd_queue
// Short command queue that decouples the front from the back engine.
// ----------------------------------------------------------------------------
`default_nettype none

module kppq_cmd_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push_valid,
	output logic                push_ready,
	input  wire kppq_pkg::cmd_t push_cmd,
	output logic                pop_valid,
	input  wire logic           pop_ready,
	output kppq_pkg::cmd_t      pop_cmd
);

	kppq_pkg::cmd_t                 buf_q [kppq_pkg::FIFO_DEPTH];
	logic [kppq_pkg::FPTR_W-1:0]    wr_ptr_q;
	logic [kppq_pkg::FPTR_W-1:0]    rd_ptr_q;
	logic [kppq_pkg::FCNT_W-1:0]    cnt_q;
	logic                           push;
	logic                           pop;

	assign push_ready = cnt_q != kppq_pkg::FCNT_W'(kppq_pkg::FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_cmd    = buf_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/kppq_back.sv
// ----------------------------------------------------------------------------
// kppq_back
// Execute commands against the slot RAM and hold the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kppq_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire kppq_pkg::cmd_t cmd,
	output logic                out_valid,
	input  wire logic           out_ready,
	output kppq_pkg::res_t      res
);

	localparam int IW = kppq_pkg::IDX_W;
	localparam int CW = kppq_pkg::CNT_W;

	// slot RAM, ring-addressed from head_q
	kppq_pkg::entry_t        mem [kppq_pkg::DEPTH];
	kppq_pkg::entry_t        rd_data_q;
	logic [IW-1:0]           rd_addr;
	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	kppq_pkg::entry_t        mem_wdata;

	kppq_pkg::back_state_t   state_q, state_d;
	kppq_pkg::cmd_t          cmd_q;
	logic [CW-1:0]           count_q, count_d;
	logic [IW-1:0]           head_q, head_d;
	logic [CW-1:0]           issue_q, issue_d;
	logic                    cmp_vld_q, cmp_vld_d;
	logic [IW-1:0]           cmp_idx_q, cmp_idx_d;
	logic [IW-1:0]           hit_idx_q, hit_idx_d;
	kppq_pkg::entry_t        found_q, found_d;
	logic                    out_valid_q;
	kppq_pkg::res_t          res_q;

	logic                    take;
	logic                    hit;
	logic                    more;
	logic                    full;
	logic                    empty;
	logic                    fin;
	kppq_pkg::res_t          fin_res;

	assign take  = cmd_valid && cmd_ready;
	assign hit   = cmp_vld_q && (rd_data_q.dst == cmd_q.entry.dst);
	assign more  = issue_q < count_q;
	assign full  = count_q == CW'(kppq_pkg::DEPTH);
	assign empty = count_q == '0;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			kppq_pkg::BS_IDLE: begin
				if (take) begin
					state_d = kppq_pkg::BS_EXEC;
				end
			end
			kppq_pkg::BS_EXEC: begin
				case (cmd_q.op)
					kppq_pkg::OP_ADD:    state_d = kppq_pkg::BS_IDLE;
					kppq_pkg::OP_LOOKUP: state_d = kppq_pkg::BS_SCAN;
					kppq_pkg::OP_DELETE: state_d = kppq_pkg::BS_SCAN;
					kppq_pkg::OP_POP: begin
						state_d = empty ? kppq_pkg::BS_IDLE : kppq_pkg::BS_POP_RD;
					end
					default: state_d = kppq_pkg::BS_IDLE;
				endcase
			end
			kppq_pkg::BS_SCAN: begin
				if (hit) begin
					state_d = (cmd_q.op == kppq_pkg::OP_DELETE) ?
						kppq_pkg::BS_DEL_WR : kppq_pkg::BS_IDLE;
				end else if (!more && !cmp_vld_q) begin
					state_d = kppq_pkg::BS_IDLE;
				end
			end
			kppq_pkg::BS_POP_RD: state_d = kppq_pkg::BS_IDLE;
			kppq_pkg::BS_DEL_WR: state_d = kppq_pkg::BS_IDLE;
			default:             state_d = kppq_pkg::BS_IDLE;
		endcase
	end

	// datapath controls and result
	always_comb begin
		cmd_ready = 1'b0;
		rd_addr   = kppq_pkg::wrap_add(head_q, issue_q[IW-1:0]);
		mem_we    = 1'b0;
		mem_waddr = kppq_pkg::wrap_add(head_q, count_q[IW-1:0]);
		mem_wdata = cmd_q.entry;
		count_d   = count_q;
		head_d    = head_q;
		issue_d   = issue_q;
		cmp_vld_d = cmp_vld_q;
		cmp_idx_d = cmp_idx_q;
		hit_idx_d = hit_idx_q;
		found_d   = found_q;
		fin       = 1'b0;
		fin_res   = '0;
		case (state_q)
			kppq_pkg::BS_IDLE: begin
				cmd_ready = !out_valid_q;
			end
			kppq_pkg::BS_EXEC: begin
				case (cmd_q.op)
					kppq_pkg::OP_ADD: begin
						fin = 1'b1;
						if (full) begin
							fin_res.status = kppq_pkg::ST_FULL;
						end else begin
							mem_we         = 1'b1;
							count_d        = count_q + 1'b1;
							fin_res.status = kppq_pkg::ST_OK;
						end
					end
					kppq_pkg::OP_POP: begin
						rd_addr = head_q;
						if (empty) begin
							fin            = 1'b1;
							fin_res.status = kppq_pkg::ST_EMPTY;
						end
					end
					default: begin
						issue_d   = '0;
						cmp_vld_d = 1'b0;
					end
				endcase
			end
			kppq_pkg::BS_POP_RD: begin
				// head read is in rd_data_q; advance the ring
				fin                 = 1'b1;
				fin_res.status      = kppq_pkg::ST_OK;
				fin_res.entry_valid = 1'b1;
				fin_res.entry       = rd_data_q;
				head_d              = kppq_pkg::wrap_add(head_q, IW'(1));
				count_d             = count_q - 1'b1;
			end
			kppq_pkg::BS_SCAN: begin
				if (hit) begin
					found_d   = rd_data_q;
					hit_idx_d = cmp_idx_q;
					cmp_vld_d = 1'b0;
					// fetch the last slot to fill the hole on delete
					rd_addr   = kppq_pkg::wrap_add(head_q, IW'(count_q - 1'b1));
					if (cmd_q.op != kppq_pkg::OP_DELETE) begin
						fin                 = 1'b1;
						fin_res.status      = kppq_pkg::ST_OK;
						fin_res.entry_valid = 1'b1;
						fin_res.entry       = rd_data_q;
					end
				end else if (more) begin
					cmp_vld_d = 1'b1;
					cmp_idx_d = issue_q[IW-1:0];
					issue_d   = issue_q + 1'b1;
				end else begin
					cmp_vld_d = 1'b0;
					if (!cmp_vld_q) begin
						fin            = 1'b1;
						fin_res.status = kppq_pkg::ST_MISS;
					end
				end
			end
			kppq_pkg::BS_DEL_WR: begin
				mem_we              = 1'b1;
				mem_waddr           = kppq_pkg::wrap_add(head_q, hit_idx_q);
				mem_wdata           = rd_data_q;
				count_d             = count_q - 1'b1;
				fin                 = 1'b1;
				fin_res.status      = kppq_pkg::ST_OK;
				fin_res.entry_valid = 1'b1;
				fin_res.entry       = found_q;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
		fin_res.occupancy = kppq_pkg::OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kppq_pkg::BS_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			cmp_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			head_q    <= head_d;
			cmp_vld_q <= cmp_vld_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_q <= cmd;
		end
		if (fin) begin
			res_q <= fin_res;
		end
		issue_q   <= issue_d;
		cmp_idx_q <= cmp_idx_d;
		hit_idx_q <= hit_idx_d;
		found_q   <= found_d;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

endmodule

`default_nettype wire

>>> rtl/core/keyed_pending_packet_queue_core.sv
// ----------------------------------------------------------------------------
// keyed_pending_packet_queue_core: keyed store of pending packet descriptors
// The back engine runs one command at a time and sets the throughput: a lookup
// or delete scans the occupied slots with one slot RAM read per cycle until a
// hit or the last slot; a delete hit then moves the last slot into the hole.
// Reset clears the entry count, ring head and all valid flags; the slot RAM
// is not cleared since only occupied slots are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "keyed_pending_packet_queue_core_defines.svh"

module keyed_pending_packet_queue_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	// request channel
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   opcode,
	input  wire logic [kppq_pkg::ADDR_W-1:0]  source_address,
	input  wire logic [kppq_pkg::ADDR_W-1:0]  destination_address,
	input  wire logic [kppq_pkg::REF_W-1:0]   message_reference,
	input  wire logic [kppq_pkg::LEN_W-1:0]   message_length,
	input  wire logic [kppq_pkg::HOP_W-1:0]   hop_limit,

	// result channel
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [1:0]                        status,
	output logic                              entry_valid,
	output logic [kppq_pkg::ADDR_W-1:0]       entry_source,
	output logic [kppq_pkg::ADDR_W-1:0]       entry_destination,
	output logic [kppq_pkg::REF_W-1:0]        entry_reference,
	output logic [kppq_pkg::LEN_W-1:0]        entry_length,
	output logic [kppq_pkg::HOP_W-1:0]        entry_hop_limit,
	output logic [kppq_pkg::OCC_W-1:0]        occupancy
);

	// front -> queue
	logic           f_valid;
	logic           f_ready;
	kppq_pkg::cmd_t f_cmd;

	// queue -> back
	logic           q_valid;
	logic           q_ready;
	kppq_pkg::cmd_t q_cmd;

	kppq_pkg::res_t res;

	// Front: accept a request transaction, decode the opcode, clamp the
	// length and hold the command in one register stage.
	kppq_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.opcode              (opcode),
		.source_address      (source_address),
		.destination_address (destination_address),
		.message_reference   (message_reference),
		.message_length      (message_length),
		.hop_limit           (hop_limit),
		.cmd_valid           (f_valid),
		.cmd_ready           (f_ready),
		.cmd                 (f_cmd)
	);

	// Queue: buffer commands so the front keeps accepting while the back
	// engine scans or waits on a stalled result.
	kppq_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_cmd   (f_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	// Back: run one command at a time against the slot ring. The ring
	// head stands in for the shift on pop; delete moves the last slot
	// into the hole.
	kppq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res       (res)
	);

	// Unpack the result register onto the port fields.
	assign status            = res.status;
	assign entry_valid       = res.entry_valid;
	assign entry_source      = res.entry.src;
	assign entry_destination = res.entry.dst;
	assign entry_reference   = res.entry.handle;
	assign entry_length      = res.entry.len;
	assign entry_hop_limit   = res.entry.hops;
	assign occupancy         = res.occupancy;

	// A rejected add only happens with every slot taken.
	`KPPQ_ASSERT_HOLDS(a_full_occ, out_valid && status == kppq_pkg::ST_FULL, occupancy == kppq_pkg::OCC_FULL)
	// Pop reports empty only with no slot taken.
	`KPPQ_ASSERT_HOLDS(a_empty_occ, out_valid && status == kppq_pkg::ST_EMPTY, occupancy == '0)
	// A returned descriptor always comes with an ok status.
	`KPPQ_ASSERT_HOLDS(a_entry_ok, out_valid && entry_valid, status == kppq_pkg::ST_OK)
	// The back engine takes a command only while the result register is free.
	`KPPQ_ASSERT_HOLDS(a_take_free, q_valid && q_ready, !out_valid)
	// Without a descriptor the entry fields read as zero.
	`KPPQ_ASSERT_HOLDS(a_zero_fields, out_valid && !entry_valid, entry_reference == '0 && entry_destination == '0)

endmodule

`default_nettype wire
